FILE: design/bst_pkg.sv
// Package for the bounded set table: port widths, operation codes and
// default sizes. Has no dependencies; imported by the top level.
`default_nettype none

package bst_pkg;

   localparam int DEF_CAPACITY      = 16;
   localparam int DEF_ELEMENT_WIDTH = 32;

   localparam int KIND_W  = 2;
   localparam int VALUE_W = 32;
   localparam int SLOT_W  = 4;
   localparam int COUNT_W = 5;

   typedef logic [KIND_W-1:0] kind_type;

   localparam kind_type KIND_ADD    = 2'd0;
   localparam kind_type KIND_REMOVE = 2'd1;
   localparam kind_type KIND_LOOKUP = 2'd2;
   localparam kind_type KIND_CLEAR  = 2'd3;

endpackage

`default_nettype wire

FILE: design/bst_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies; used by the bounded set table for its element store.
`default_nettype none

module bst_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: design/bounded_set_table_core.sv
// Top level of the bounded set table: control sequencer, fill count and
// result register around one bst_ram element store. Depends on bst_pkg.
//
//   channel   direction  handshake              payload
//   req       in         req_valid / req_ready  req_kind, req_value
//   rsp       out        rsp_valid / rsp_ready  rsp_success, rsp_found,
//                                               rsp_found_slot, rsp_count,
//                                               rsp_empty_res
//
// One item at a time. A search reads one stored entry per cycle through the
// RAM read port and ends on a match or after the last stored entry; a remove
// that hits then reads the last entry and writes it into the freed slot, and
// a clear skips the search and goes straight to loading the result register.
// Reset (synchronous) empties the set; the RAM contents are not cleared.
// The result register frees the input side: the next item is taken while a
// result still waits, and only the final load stalls on rsp_ready.
`default_nettype none

module bounded_set_table_core #(
   parameter int CAPACITY      = bst_pkg::DEF_CAPACITY,
   parameter int ELEMENT_WIDTH = bst_pkg::DEF_ELEMENT_WIDTH
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  bst_pkg::kind_type            req_kind,
   input  logic [bst_pkg::VALUE_W-1:0]  req_value,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_success,
   output logic                         rsp_found,
   output logic [bst_pkg::SLOT_W-1:0]   rsp_found_slot,
   output logic [bst_pkg::COUNT_W-1:0]  rsp_count,
   output logic                         rsp_empty_res
);

   import bst_pkg::*;

   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_XW = CNT_W + COUNT_W;
   localparam int IDX_XW = IDX_W + SLOT_W;
   localparam int VAL_XW = ELEMENT_WIDTH + VALUE_W;

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_SCAN    = 3'd1;
   localparam logic [2:0] S_MOVE_RD = 3'd2;
   localparam logic [2:0] S_MOVE_WR = 3'd3;
   localparam logic [2:0] S_DONE    = 3'd4;

   logic [2:0]               state_ff, state_in;
   kind_type                 kind_ff, kind_in;
   logic [ELEMENT_WIDTH-1:0] val_ff, val_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [CNT_W-1:0]         issue_ff, issue_in;
   logic                     pend_ff, pend_in;
   logic [IDX_W-1:0]         pend_idx_ff, pend_idx_in;
   logic                     hit_ff, hit_in;
   logic [IDX_W-1:0]         slot_ff, slot_in;
   logic                     ok_ff, ok_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_success_ff, rsp_success_in;
   logic                     rsp_found_ff, rsp_found_in;
   logic [SLOT_W-1:0]        rsp_slot_ff, rsp_slot_in;
   logic [COUNT_W-1:0]       rsp_count_ff, rsp_count_in;
   logic                     rsp_empty_ff, rsp_empty_in;

   logic                     wr_en;
   logic [IDX_W-1:0]         wr_addr;
   logic [ELEMENT_WIDTH-1:0] wr_data;
   logic                     rd_en;
   logic [IDX_W-1:0]         rd_addr;
   logic [ELEMENT_WIDTH-1:0] rd_data;

   logic [VAL_XW-1:0]        val_wide;
   logic [CNT_XW-1:0]        count_wide;
   logic [IDX_XW-1:0]        slot_wide;
   logic                     match;
   logic                     scan_end;

   bst_ram #(
      .WIDTH (ELEMENT_WIDTH),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign val_wide   = VAL_XW'(req_value);
   assign count_wide = CNT_XW'(count_ff);
   assign slot_wide  = IDX_XW'(slot_ff);

   // The entry read last cycle is compared now; the scan ends on the first
   // match or once every stored slot has been issued and compared.
   assign match    = pend_ff && (rd_data == val_ff);
   assign scan_end = match || (issue_ff >= count_ff);

   always_comb begin
      state_in       = state_ff;
      kind_in        = kind_ff;
      val_in         = val_ff;
      count_in       = count_ff;
      issue_in       = issue_ff;
      pend_in        = 1'b0;
      pend_idx_in    = pend_idx_ff;
      hit_in         = hit_ff;
      slot_in        = slot_ff;
      ok_in          = ok_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_success_in = rsp_success_ff;
      rsp_found_in   = rsp_found_ff;
      rsp_slot_in    = rsp_slot_ff;
      rsp_count_in   = rsp_count_ff;
      rsp_empty_in   = rsp_empty_ff;
      wr_en          = 1'b0;
      wr_addr        = count_ff[IDX_W-1:0];
      wr_data        = val_ff;
      rd_en          = 1'b0;
      rd_addr        = issue_ff[IDX_W-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               kind_in  = req_kind;
               val_in   = val_wide[ELEMENT_WIDTH-1:0];
               issue_in = '0;
               hit_in   = 1'b0;
               slot_in  = '0;
               if (req_kind == KIND_CLEAR) begin
                  count_in = '0;
                  ok_in    = 1'b1;
                  state_in = S_DONE;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (scan_end) begin
               hit_in   = match;
               slot_in  = match ? pend_idx_ff : '0;
               state_in = S_DONE;
               case (kind_ff)
                  KIND_ADD: begin
                     if (!match && (count_ff < CNT_W'(CAPACITY))) begin
                        wr_en    = 1'b1;
                        count_in = count_ff + 1'b1;
                        ok_in    = 1'b1;
                     end else begin
                        ok_in = 1'b0;
                     end
                  end
                  KIND_REMOVE: begin
                     ok_in = match;
                     if (match) begin
                        count_in = count_ff - 1'b1;
                        state_in = S_MOVE_RD;
                     end
                  end
                  default: begin
                     ok_in = match;
                  end
               endcase
            end else begin
               rd_en       = 1'b1;
               pend_in     = 1'b1;
               pend_idx_in = issue_ff[IDX_W-1:0];
               issue_in    = issue_ff + 1'b1;
            end
         end
         S_MOVE_RD: begin
            // count_ff already holds the decremented count: it indexes the last entry.
            rd_en    = 1'b1;
            rd_addr  = count_ff[IDX_W-1:0];
            state_in = S_MOVE_WR;
         end
         S_MOVE_WR: begin
            wr_en    = 1'b1;
            wr_addr  = slot_ff;
            wr_data  = rd_data;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in   = 1'b1;
               rsp_success_in = ok_ff;
               rsp_found_in   = hit_ff;
               rsp_slot_in    = slot_wide[SLOT_W-1:0];
               rsp_count_in   = count_wide[COUNT_W-1:0];
               rsp_empty_in   = (count_ff == '0);
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff        <= kind_in;
      val_ff         <= val_in;
      issue_ff       <= issue_in;
      pend_idx_ff    <= pend_idx_in;
      hit_ff         <= hit_in;
      slot_ff        <= slot_in;
      ok_ff          <= ok_in;
      rsp_success_ff <= rsp_success_in;
      rsp_found_ff   <= rsp_found_in;
      rsp_slot_ff    <= rsp_slot_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_empty_ff   <= rsp_empty_in;
   end

   assign req_ready      = (state_ff == S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_success    = rsp_success_ff;
   assign rsp_found      = rsp_found_ff;
   assign rsp_found_slot = rsp_slot_ff;
   assign rsp_count      = rsp_count_ff;
   assign rsp_empty_res  = rsp_empty_ff;

endmodule

`default_nettype wire
